@@ hw/rtl/fat_short_name_packer_top_macros.svh @@
// assertion macros used by the checker file
`ifndef FAT_SHORT_NAME_PACKER_TOP_MACROS_SVH
`define FAT_SHORT_NAME_PACKER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define FSNP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fsnp check failed: same-cycle rule");

// next-cycle implication, disabled while reset is high
`define FSNP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fsnp check failed: next-cycle rule");

`endif

@@ hw/rtl/fsnp_pkg.sv @@
package fsnp_pkg;

   // character codes
   localparam logic [7:0] NUL_BYTE    = 8'h00;
   localparam logic [7:0] SPACE_BYTE  = 8'h20;
   localparam logic [7:0] DOT_BYTE    = 8'h2E;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   // 8.3 field sizes
   localparam logic [3:0] BASE_LEN = 4'd8;
   localparam logic [1:0] EXT_LEN  = 2'd3;

   localparam logic [63:0] BASE_SPACES = {8{SPACE_BYTE}};
   localparam logic [23:0] EXT_SPACES  = {3{SPACE_BYTE}};

   // one packed short name
   typedef struct packed {
      logic [63:0] base_part;
      logic [23:0] ext_part;
      logic        name_ok;
   } result_type;

   // 0 or space ends a name
   function automatic logic is_term(input logic [7:0] ch);
      is_term = (ch == NUL_BYTE) || (ch == SPACE_BYTE);
   endfunction

   // a..z to upper case, everything else unchanged
   function automatic logic [7:0] fold_case(input logic [7:0] ch);
      if ((ch >= LOWER_A) && (ch <= LOWER_Z)) begin
         fold_case = ch - CASE_OFFSET;
      end else begin
         fold_case = ch;
      end
   endfunction

endpackage

@@ hw/rtl/fsnp_in_stage.sv @@
module fsnp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_name_byte,
   input  logic       in_take,
   output logic       in_vld,
   output logic [7:0] in_byte
);

   logic       in_vld_ff;
   logic       in_vld_in;
   logic [7:0] in_byte_ff;

   // slot is free when empty or being consumed this cycle
   assign req_ready = !in_vld_ff || in_take;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (in_take) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // byte register, loaded on each input transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_name_byte;
      end
   end

   assign in_vld  = in_vld_ff;
   assign in_byte = in_byte_ff;

endmodule

@@ hw/rtl/fsnp_core.sv @@
module fsnp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  logic [7:0]           in_byte,
   input  logic                 out_free,
   output logic                 in_take,
   output logic                 res_load,
   output fsnp_pkg::result_type res
);

   logic [63:0] base_bytes_ff, base_bytes_in;
   logic [23:0] ext_bytes_ff, ext_bytes_in;
   logic [3:0]  base_count_ff, base_count_in;
   logic [1:0]  ext_count_ff, ext_count_in;
   logic        in_ext_ff, in_ext_in;
   logic        failed_ff, failed_in;

   logic       term;
   logic [7:0] ch;
   logic       base_wr;
   logic       ext_wr;

   assign term = fsnp_pkg::is_term(in_byte);
   assign ch   = fsnp_pkg::fold_case(in_byte);

   // a terminator waits for the result slot, other bytes never stall
   assign in_take  = in_vld && (!term || out_free);
   assign res_load = in_vld && term && out_free;

   // result is the name as stored so far
   always_comb begin
      res.base_part = base_bytes_ff;
      res.ext_part  = ext_bytes_ff;
      res.name_ok   = !failed_ff && (base_count_ff != 4'd0);
   end

   // next state
   always_comb begin
      base_bytes_in = base_bytes_ff;
      ext_bytes_in  = ext_bytes_ff;
      base_count_in = base_count_ff;
      ext_count_in  = ext_count_ff;
      in_ext_in     = in_ext_ff;
      failed_in     = failed_ff;
      base_wr       = 1'b0;
      ext_wr        = 1'b0;

      if (in_take) begin
         if (term) begin
            // back to the empty name
            base_bytes_in = fsnp_pkg::BASE_SPACES;
            ext_bytes_in  = fsnp_pkg::EXT_SPACES;
            base_count_in = 4'd0;
            ext_count_in  = 2'd0;
            in_ext_in     = 1'b0;
            failed_in     = 1'b0;
         end else if (!failed_ff) begin
            if (in_byte == fsnp_pkg::DOT_BYTE) begin
               // only one dot, and only after a non-empty base
               if (!in_ext_ff && (base_count_ff != 4'd0)) begin
                  in_ext_in = 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end else if (in_ext_ff) begin
               if (ext_count_ff == fsnp_pkg::EXT_LEN) begin
                  failed_in = 1'b1;
               end else begin
                  ext_wr       = 1'b1;
                  ext_count_in = ext_count_ff + 2'd1;
               end
            end else begin
               if (base_count_ff >= fsnp_pkg::BASE_LEN) begin
                  failed_in = 1'b1;
               end else begin
                  base_wr       = 1'b1;
                  base_count_in = base_count_ff + 4'd1;
               end
            end
         end
      end

      // byte lane writes, first character in the top lane
      for (int i = 0; i < 8; i++) begin
         if (base_wr && (base_count_ff[2:0] == 3'(i))) begin
            base_bytes_in[63 - 8*i -: 8] = ch;
         end
      end
      for (int j = 0; j < 3; j++) begin
         if (ext_wr && (ext_count_ff == 2'(j))) begin
            ext_bytes_in[23 - 8*j -: 8] = ch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_bytes_ff <= fsnp_pkg::BASE_SPACES;
         ext_bytes_ff  <= fsnp_pkg::EXT_SPACES;
         base_count_ff <= 4'd0;
         ext_count_ff  <= 2'd0;
         in_ext_ff     <= 1'b0;
         failed_ff     <= 1'b0;
      end else begin
         base_bytes_ff <= base_bytes_in;
         ext_bytes_ff  <= ext_bytes_in;
         base_count_ff <= base_count_in;
         ext_count_ff  <= ext_count_in;
         in_ext_ff     <= in_ext_in;
         failed_ff     <= failed_in;
      end
   end

endmodule

@@ hw/rtl/fsnp_out_reg.sv @@
module fsnp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_load,
   input  fsnp_pkg::result_type res,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_base_part,
   output logic [23:0]          rsp_ext_part,
   output logic                 rsp_name_ok
);

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   fsnp_pkg::result_type res_ff;

   // free when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_base_part = res_ff.base_part;
   assign rsp_ext_part  = res_ff.ext_part;
   assign rsp_name_ok   = res_ff.name_ok;

endmodule

@@ hw/rtl/fat_short_name_packer_top.sv @@
// FAT 8.3 short-name packer. Feed a file name one byte per transfer on the
// req_ channel; a byte of 0x00 or 0x20 ends the name and produces one result
// on the rsp_ channel: eight space-padded base bytes (first character in bits
// 63:56), three space-padded extension bytes (first in bits 23:16) and
// name_ok, set when the name fits 8.3 with a non-empty base and at most one
// dot after it. Letters a-z are stored upper case. One byte is accepted every
// cycle while no terminator is stalled; a name byte updates the state register
// at the clock edge after its transfer, and a result is loaded into the rsp_
// register once its terminator, held in the input register, finds that register
// free. Only a terminator can stall, when the result register still holds an
// untaken result; req_ready then follows rsp_ready in the same cycle.
module fat_short_name_packer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_name_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_base_part,
   output logic [23:0] rsp_ext_part,
   output logic        rsp_name_ok
);

   logic                 in_take;
   logic                 in_vld;
   logic [7:0]           in_byte;
   logic                 out_free;
   logic                 res_load;
   fsnp_pkg::result_type res;

   // input register
   fsnp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_name_byte (req_name_byte),
      .in_take       (in_take),
      .in_vld        (in_vld),
      .in_byte       (in_byte)
   );

   // name state and packing
   fsnp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (in_vld),
      .in_byte  (in_byte),
      .out_free (out_free),
      .in_take  (in_take),
      .res_load (res_load),
      .res      (res)
   );

   // result register
   fsnp_out_reg u_out_reg (
      .clock         (clock),
      .reset         (reset),
      .res_load      (res_load),
      .res           (res),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_base_part (rsp_base_part),
      .rsp_ext_part  (rsp_ext_part),
      .rsp_name_ok   (rsp_name_ok)
   );

endmodule

@@ hw/rtl/fsnp_checker.sv @@
`include "fat_short_name_packer_top_macros.svh"

module fsnp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_name_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_base_part,
   input logic [23:0] rsp_ext_part,
   input logic        rsp_name_ok
);

   logic [88:0] rsp_payload;
   logic        first_real;
   logic        base_lower;
   logic        ext_lower;

   assign rsp_payload = {rsp_base_part, rsp_ext_part, rsp_name_ok};

   // first base character is neither padding, terminator nor dot
   assign first_real = (rsp_base_part[63:56] != fsnp_pkg::SPACE_BYTE) &&
                       (rsp_base_part[63:56] != fsnp_pkg::NUL_BYTE) &&
                       (rsp_base_part[63:56] != fsnp_pkg::DOT_BYTE);

   // lower-case letter in the first lane of each part
   assign base_lower = (rsp_base_part[63:56] >= fsnp_pkg::LOWER_A) &&
                       (rsp_base_part[63:56] <= fsnp_pkg::LOWER_Z);
   assign ext_lower  = (rsp_ext_part[23:16] >= fsnp_pkg::LOWER_A) &&
                       (rsp_ext_part[23:16] <= fsnp_pkg::LOWER_Z);

   // a waiting input transfer keeps its byte
   `FSNP_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_name_byte))

   // a stalled result keeps its payload
   `FSNP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // nothing left over from before reset
   `FSNP_ASSERT_NOW(a_rsp_clear, clock, reset, $past(reset), !rsp_valid)

   // a good name starts with a real character
   `FSNP_ASSERT_NOW(a_ok_first, clock, reset, rsp_valid && rsp_name_ok, first_real)

   // the first stored letter of each part is upper case
   `FSNP_ASSERT_NOW(a_upper, clock, reset, rsp_valid, !base_lower && !ext_lower)

endmodule

bind fat_short_name_packer_top fsnp_checker u_fsnp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_name_byte (req_name_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_base_part (rsp_base_part),
   .rsp_ext_part  (rsp_ext_part),
   .rsp_name_ok   (rsp_name_ok)
);

@@ tb/fat_short_name_packer_top_tb.sv @@
`timescale 1ns / 1ps

module fat_short_name_packer_top_tb;

   localparam int RSP_HOLD_CYCLES = 300;
   localparam int MAX_REPORTS     = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_name_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_base_part;
   logic [23:0] rsp_ext_part;
   logic        rsp_name_ok;

   // random idle rates in percent, and the long receiver hold-off
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   logic        rsp_hold = 1'b0;

   int unsigned bytes_sent     = 0;
   int unsigned mismatch_count = 0;
   int unsigned fail_count     = 0;

   // short names still to come out of the block, oldest first
   fsnp_pkg::result_type expected_names[$];

   // packer state as the block should hold it
   logic [63:0] pk_base;
   logic [23:0] pk_ext;
   logic [3:0]  pk_base_cnt;
   logic [1:0]  pk_ext_cnt;
   logic        pk_in_ext;
   logic        pk_failed;

   fat_short_name_packer_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_name_byte (req_name_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_base_part (rsp_base_part),
      .rsp_ext_part  (rsp_ext_part),
      .rsp_name_ok   (rsp_name_ok)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #5000000;
      $display("FAIL fat_short_name_packer_top");
      $finish;
   end

   function automatic void clear_packer_state();
      pk_base     = fsnp_pkg::BASE_SPACES;
      pk_ext      = fsnp_pkg::EXT_SPACES;
      pk_base_cnt = '0;
      pk_ext_cnt  = '0;
      pk_in_ext   = 1'b0;
      pk_failed   = 1'b0;
   endfunction

   // fold one accepted byte into the predicted short name
   function automatic void predict_name_byte(input logic [7:0] b);
      logic [7:0] ch;
      fsnp_pkg::result_type r;
      if ((b == fsnp_pkg::NUL_BYTE) || (b == fsnp_pkg::SPACE_BYTE)) begin
         r.base_part = pk_base;
         r.ext_part  = pk_ext;
         r.name_ok   = !pk_failed && (pk_base_cnt != 0);
         expected_names.push_back(r);
         clear_packer_state();
      end else if (!pk_failed) begin
         if (b == fsnp_pkg::DOT_BYTE) begin
            if (!pk_in_ext && (pk_base_cnt != 0)) begin
               pk_in_ext = 1'b1;
            end else begin
               pk_failed = 1'b1;
            end
         end else begin
            ch = b;
            if ((ch >= fsnp_pkg::LOWER_A) && (ch <= fsnp_pkg::LOWER_Z)) begin
               ch = ch - fsnp_pkg::CASE_OFFSET;
            end
            if (pk_in_ext) begin
               if (pk_ext_cnt >= fsnp_pkg::EXT_LEN) begin
                  pk_failed = 1'b1;
               end else begin
                  pk_ext[8 * (2 - int'(pk_ext_cnt)) +: 8] = ch;
                  pk_ext_cnt = pk_ext_cnt + 2'd1;
               end
            end else begin
               if (pk_base_cnt >= fsnp_pkg::BASE_LEN) begin
                  pk_failed = 1'b1;
               end else begin
                  pk_base[8 * (7 - int'(pk_base_cnt)) +: 8] = ch;
                  pk_base_cnt = pk_base_cnt + 4'd1;
               end
            end
         end
      end
   endfunction

   // receiver: random idling plus the long hold-off
   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // compare each result transfer with the oldest predicted name
   always @(posedge clock) begin
      fsnp_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_names.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected result: base %h ext %h ok %b",
                        rsp_base_part, rsp_ext_part, rsp_name_ok);
            end
         end else begin
            want = expected_names.pop_front();
            if ((rsp_base_part !== want.base_part) || (rsp_ext_part !== want.ext_part) ||
                (rsp_name_ok !== want.name_ok)) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch: expected base %h ext %h ok %b, got base %h ext %h ok %b",
                           want.base_part, want.ext_part, want.name_ok,
                           rsp_base_part, rsp_ext_part, rsp_name_ok);
               end
            end
         end
      end
   end

   // one byte transfer on the req_ channel, with random idle cycles first
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_name_byte <= b;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_name_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   // sender stops until every predicted name has come out
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_names.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // any byte that neither ends a name nor is a dot, weighted toward letters
   function automatic logic [7:0] random_name_char();
      int unsigned pick;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 40) begin
         b = 8'($urandom_range(fsnp_pkg::LOWER_A, fsnp_pkg::LOWER_Z));
      end else if (pick < 65) begin
         b = 8'($urandom_range(8'h41, 8'h5A));
      end else if (pick < 80) begin
         b = 8'($urandom_range(8'h30, 8'h39));
      end else begin
         do begin
            b = 8'($urandom_range(1, 255));
         end while ((b == fsnp_pkg::DOT_BYTE) || (b == fsnp_pkg::SPACE_BYTE));
      end
      return b;
   endfunction

   // one name: mostly well formed, some broken, some pure noise
   task automatic send_random_name();
      int unsigned kind;
      int unsigned blen;
      int unsigned elen;
      int unsigned extra_dot;
      kind = $urandom_range(99);
      if (kind < 75) begin
         blen = $urandom_range(1, 8);
         for (int i = 0; i < blen; i++) send_byte(random_name_char());
         if ($urandom_range(3) != 0) begin
            send_byte(fsnp_pkg::DOT_BYTE);
            elen = $urandom_range(0, 3);
            for (int i = 0; i < elen; i++) send_byte(random_name_char());
         end
      end else if (kind < 90) begin
         // broken: overlong parts, missing base or a stray dot
         blen = $urandom_range(0, 11);
         elen = $urandom_range(0, 5);
         extra_dot = $urandom_range(0, 15);
         for (int i = 0; i < blen; i++) begin
            if (i == extra_dot) send_byte(fsnp_pkg::DOT_BYTE);
            send_byte(random_name_char());
         end
         if ($urandom_range(4) != 0) send_byte(fsnp_pkg::DOT_BYTE);
         for (int i = 0; i < elen; i++) begin
            if (i + blen == extra_dot) send_byte(fsnp_pkg::DOT_BYTE);
            send_byte(random_name_char());
         end
      end else begin
         // noise: any byte values, terminators included
         blen = $urandom_range(1, 12);
         for (int i = 0; i < blen; i++) begin
            if ($urandom_range(4) == 0) begin
               send_byte(fsnp_pkg::DOT_BYTE);
            end else begin
               send_byte(8'($urandom_range(0, 255)));
            end
         end
      end
      send_byte($urandom_range(1) ? fsnp_pkg::NUL_BYTE : fsnp_pkg::SPACE_BYTE);
   endtask

   // terminator first, with both terminator codes
   task automatic test_empty_name();
      send_byte(fsnp_pkg::NUL_BYTE);
      send_byte(fsnp_pkg::SPACE_BYTE);
   endtask

   // leading dot, second dot, dot right before the end
   task automatic test_dot_placement();
      send_byte(fsnp_pkg::DOT_BYTE);
      send_byte(fsnp_pkg::NUL_BYTE);
      send_text("a..");
      send_byte(fsnp_pkg::SPACE_BYTE);
      send_text("z.");
      send_byte(fsnp_pkg::NUL_BYTE);
   endtask

   // ninth base character, carrying the byte-value extremes and case edges
   task automatic test_base_overflow();
      send_byte(8'h01);
      send_text("`{");
      send_byte(8'h7F);
      send_byte(8'h80);
      send_text("y");
      send_byte(8'hFF);
      send_text("ab");
      send_byte(fsnp_pkg::NUL_BYTE);
   endtask

   // fourth extension character
   task automatic test_ext_overflow();
      send_text("q.az{~");
      send_byte(fsnp_pkg::SPACE_BYTE);
   endtask

   task automatic test_random_names(input int unsigned n_bytes);
      int unsigned stop_at;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         send_random_name();
      end
   endtask

   // receiver holds off while the sender keeps offering, then drain
   task automatic test_backpressure();
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (int i = 0; i < 8; i++) begin
         send_random_name();
      end
      wait_for_results();
   endtask

   initial begin
      clear_packer_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 9;
      rsp_idle_pct = 47;
      test_empty_name();
      test_dot_placement();
      test_base_overflow();
      test_ext_overflow();
      test_random_names(650);
      test_backpressure();

      req_idle_pct = 47;
      rsp_idle_pct = 9;
      test_random_names(650);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_names(650);

      wait_for_results();
      repeat (10) @(posedge clock);
      if (expected_names.size() != 0) begin
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("PASS fat_short_name_packer_top");
      end else begin
         $display("FAIL fat_short_name_packer_top");
      end
      $finish;
   end

endmodule
